### hw/rtl/lut3d_pkg.sv
package lut3d_pkg;

  localparam int MaxDim     = 33;
  localparam int SampleBits = 16;
  localparam int DimW       = 6;
  localparam int CellW      = $clog2(MaxDim);
  localparam int Half       = (MaxDim + 1) / 2;
  localparam int BankDepth  = Half * Half * Half;
  localparam int BankAw     = $clog2(BankDepth);
  localparam int NumBanks   = 8;
  localparam int ProdW      = DimW + SampleBits;
  localparam int WgtW       = SampleBits + 1;
  localparam logic [SampleBits-1:0] FullScale = {SampleBits{1'b1}};
  localparam logic [WgtW-1:0] WgtOne = {1'b1, {SampleBits{1'b0}}};

  // tuser codes on the request channel
  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncPixel = 1'b1;

  typedef logic [SampleBits-1:0] smp_t;
  typedef logic [CellW-1:0]      cell_t;
  typedef logic [BankAw-1:0]     baddr_t;
  typedef logic [WgtW-1:0]       wgt_t;
  typedef logic [2:0]            bank_t;
  typedef smp_t [2:0]            ent_t;

  typedef struct packed {
    logic          pix;
    logic          loaded;
    ent_t          v;
    cell_t [2:0]   lc;
  } s0_t;

  typedef struct packed {
    logic                   pix;
    logic                   loaded;
    ent_t                   v;
    baddr_t [NumBanks-1:0]  baddr;
    bank_t  [3:0]           cbank;
    wgt_t   [3:0]           w;
  } s3_t;

  typedef struct packed {
    logic          loaded;
    ent_t          v;
    bank_t [3:0]   cbank;
    wgt_t  [3:0]   w;
  } s4_t;

endpackage

### hw/rtl/lut3d_ram.sv
module lut3d_ram #(
  parameter int Depth = 4913,
  parameter int Width = 48,
  parameter int Aw    = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [Aw-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [Aw-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/lut3d_front.sv
module lut3d_front (
  input  logic               clk,
  input  logic [3:1]         ld,
  input  lut3d_pkg::s0_t     s0,
  input  lut3d_pkg::cell_t   dimm1,
  output lut3d_pkg::s3_t     s3
);
  import lut3d_pkg::*;

  // stage 1: scale by dim-1
  logic                    pix1_r, loaded1_r;
  ent_t                    v1_r;
  cell_t [2:0]             lc1_r;
  logic [2:0][ProdW-1:0]   p1_r;

  // stage 2: cell indices and fractions
  logic        pix2_r, loaded2_r;
  ent_t        v2_r;
  cell_t [2:0] lo2_r, hi2_r;
  smp_t  [2:0] f2_r;

  cell_t [2:0] lo_nxt, hi_nxt;
  smp_t  [2:0] f_nxt;
  s3_t         s3_r, s3_nxt;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      pix1_r    <= s0.pix;
      loaded1_r <= s0.loaded;
      v1_r      <= s0.v;
      lc1_r     <= s0.lc;
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= ProdW'(s0.v[i]) * ProdW'(dimm1);
      end
    end
  end

  // p / FullScale: quotient fits in 6 bits, one correction step
  always_comb begin
    logic [SampleBits:0] rem;
    cell_t               q, c;
    for (int i = 0; i < 3; i++) begin
      q   = p1_r[i][ProdW-1:SampleBits];
      rem = {1'b0, p1_r[i][SampleBits-1:0]} + (SampleBits+1)'(q);
      if (rem >= {1'b0, FullScale}) begin
        c        = q + cell_t'(1);
        f_nxt[i] = smp_t'(rem - {1'b0, FullScale});
      end else begin
        c        = q;
        f_nxt[i] = rem[SampleBits-1:0];
      end
      if (c > dimm1) c = dimm1;
      lo_nxt[i] = pix1_r ? c : lc1_r[i];
      hi_nxt[i] = (lo_nxt[i] == dimm1) ? lo_nxt[i] : lo_nxt[i] + cell_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      pix2_r    <= pix1_r;
      loaded2_r <= loaded1_r;
      v2_r      <= v1_r;
      lo2_r     <= lo_nxt;
      hi2_r     <= hi_nxt;
      f2_r      <= f_nxt;
    end
  end

  // tetrahedron pick, weights, per-bank addresses
  always_comb begin
    smp_t  fx, fy, fz;
    bank_t sel1, sel2;
    cell_t rx, gx, bx;
    fx = f2_r[2'd0];
    fy = f2_r[2'd1];
    fz = f2_r[2'd2];
    s3_nxt        = '0;
    s3_nxt.pix    = pix2_r;
    s3_nxt.loaded = loaded2_r;
    s3_nxt.v      = v2_r;
    if (fx > fy) begin
      if (fy > fz) begin
        sel1 = 3'b100; sel2 = 3'b110;
        s3_nxt.w[0] = WgtOne - wgt_t'(fx); s3_nxt.w[1] = wgt_t'(fx - fy);
        s3_nxt.w[2] = wgt_t'(fy - fz);     s3_nxt.w[3] = wgt_t'(fz);
      end else if (fx > fz) begin
        sel1 = 3'b100; sel2 = 3'b101;
        s3_nxt.w[0] = WgtOne - wgt_t'(fx); s3_nxt.w[1] = wgt_t'(fx - fz);
        s3_nxt.w[2] = wgt_t'(fz - fy);     s3_nxt.w[3] = wgt_t'(fy);
      end else begin
        sel1 = 3'b001; sel2 = 3'b101;
        s3_nxt.w[0] = WgtOne - wgt_t'(fz); s3_nxt.w[1] = wgt_t'(fz - fx);
        s3_nxt.w[2] = wgt_t'(fx - fy);     s3_nxt.w[3] = wgt_t'(fy);
      end
    end else begin
      if (fz > fy) begin
        sel1 = 3'b001; sel2 = 3'b011;
        s3_nxt.w[0] = WgtOne - wgt_t'(fz); s3_nxt.w[1] = wgt_t'(fz - fy);
        s3_nxt.w[2] = wgt_t'(fy - fx);     s3_nxt.w[3] = wgt_t'(fx);
      end else if (fz > fx) begin
        sel1 = 3'b010; sel2 = 3'b011;
        s3_nxt.w[0] = WgtOne - wgt_t'(fy); s3_nxt.w[1] = wgt_t'(fy - fz);
        s3_nxt.w[2] = wgt_t'(fz - fx);     s3_nxt.w[3] = wgt_t'(fx);
      end else begin
        sel1 = 3'b010; sel2 = 3'b110;
        s3_nxt.w[0] = WgtOne - wgt_t'(fy); s3_nxt.w[1] = wgt_t'(fy - fx);
        s3_nxt.w[2] = wgt_t'(fx - fz);     s3_nxt.w[3] = wgt_t'(fz);
      end
    end
    s3_nxt.cbank[0] = {lo2_r[2'd0][0], lo2_r[2'd1][0], lo2_r[2'd2][0]};
    s3_nxt.cbank[3] = {hi2_r[2'd0][0], hi2_r[2'd1][0], hi2_r[2'd2][0]};
    s3_nxt.cbank[1] = {sel1[2] ? hi2_r[2'd0][0] : lo2_r[2'd0][0],
                       sel1[1] ? hi2_r[2'd1][0] : lo2_r[2'd1][0],
                       sel1[0] ? hi2_r[2'd2][0] : lo2_r[2'd2][0]};
    s3_nxt.cbank[2] = {sel2[2] ? hi2_r[2'd0][0] : lo2_r[2'd0][0],
                       sel2[1] ? hi2_r[2'd1][0] : lo2_r[2'd1][0],
                       sel2[0] ? hi2_r[2'd2][0] : lo2_r[2'd2][0]};
    // bank k holds the corner whose index parities equal k
    for (int k = 0; k < NumBanks; k++) begin
      rx = (lo2_r[2'd0][0] == k[2]) ? lo2_r[2'd0] : hi2_r[2'd0];
      gx = (lo2_r[2'd1][0] == k[1]) ? lo2_r[2'd1] : hi2_r[2'd1];
      bx = (lo2_r[2'd2][0] == k[0]) ? lo2_r[2'd2] : hi2_r[2'd2];
      s3_nxt.baddr[k] = baddr_t'(baddr_t'(rx[CellW-1:1]) * baddr_t'(Half * Half))
                      + baddr_t'(baddr_t'(gx[CellW-1:1]) * baddr_t'(Half))
                      + baddr_t'(bx[CellW-1:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_r <= s3_nxt;
    end
  end

  assign s3 = s3_r;

endmodule

### hw/rtl/lut3d_blend.sv
module lut3d_blend (
  input  logic                                clk,
  input  logic [7:5]                          ld,
  input  lut3d_pkg::s4_t                      s4,
  input  lut3d_pkg::ent_t [lut3d_pkg::NumBanks-1:0] q,
  output lut3d_pkg::ent_t                     res,
  output logic                                applied
);
  import lut3d_pkg::*;

  localparam int MulW = WgtW + SampleBits;
  localparam int AccW = MulW + 2;

  logic            loaded5_r, loaded6_r, applied_r;
  ent_t            v5_r, v6_r, res_r;
  ent_t [3:0]      d5_r;
  wgt_t [3:0]      w5_r;
  logic [2:0][3:0][MulW-1:0] m6_r;
  ent_t            res_nxt;

  // corner select from the eight banks
  always_ff @(posedge clk) begin
    if (ld[5]) begin
      loaded5_r <= s4.loaded;
      v5_r      <= s4.v;
      w5_r      <= s4.w;
      for (int i = 0; i < 4; i++) begin
        d5_r[i] <= q[s4.cbank[i]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      loaded6_r <= loaded5_r;
      v6_r      <= v5_r;
      for (int ch = 0; ch < 3; ch++) begin
        for (int i = 0; i < 4; i++) begin
          m6_r[ch][i] <= MulW'(w5_r[i]) * MulW'(d5_r[i][ch]);
        end
      end
    end
  end

  // round half up, clamp to full scale; without a loaded table the input passes through
  always_comb begin
    logic [AccW-1:0] acc;
    for (int ch = 0; ch < 3; ch++) begin
      acc = AccW'(m6_r[ch][0]) + AccW'(m6_r[ch][1]) + AccW'(m6_r[ch][2])
          + AccW'(m6_r[ch][3]) + AccW'(WgtOne >> 1);
      if (acc[AccW-1:SampleBits] > (AccW-SampleBits)'(FullScale)) begin
        res_nxt[ch] = FullScale;
      end else begin
        res_nxt[ch] = acc[2*SampleBits-1:SampleBits];
      end
      if (!loaded6_r) res_nxt[ch] = v6_r[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      res_r     <= res_nxt;
      applied_r <= loaded6_r;
    end
  end

  assign res     = res_r;
  assign applied = applied_r;

endmodule

### hw/rtl/lut3d_tetrahedral_interp_core.sv
// Throughput: one request per cycle unless out_tready backs the pipeline up to the input,
// loads and pixels alike; a load yields no result.
// The table sits in eight single-read banks split by index parity, so all four
//   tetrahedron corners are fetched in the same cycle.
// Reset (rst_n, synchronous, low): pipeline empty, load pointer zero, table unloaded,
//   dimension 33. Table contents are not cleared.
module lut3d_tetrahedral_interp_core (
  input  logic        clk,
  input  logic        rst_n,
  // config: lut_dim
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // red_in[15:0], green_in[31:16], blue_in[47:32]
  input  logic        in_tuser,   // func
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // red_out[15:0], green_out[31:16], blue_out[47:32]
  output logic        out_tuser   // applied
);
  import lut3d_pkg::*;

  // stage valids: 0 accept, 1-3 front, 4 bank data, 5-6 blend, 7 output
  logic [7:0] vld_r;
  logic [8:0] ld;
  logic [7:0] vin;

  cell_t       dimm1_r;
  cell_t [2:0] lp_r;        // load pointer as r/g/b indices
  logic        loaded_r;
  s0_t         s0_r;
  s3_t         s3;
  s4_t         s4_r;
  ent_t [NumBanks-1:0] q;
  ent_t        res;
  logic        applied;
  logic        in_acc, load_acc;
  cell_t       cfg_m1;

  // a stage loads when empty or when the one after it is moving
  always_comb begin
    ld[8] = out_tready;
    for (int k = 7; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  always_comb begin
    vin    = {vld_r[6:0], 1'b0};
    vin[0] = in_tvalid;
    vin[4] = vld_r[3] && s3.pix;   // loads retire after the bank write
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < 8; k++) begin
        if (ld[k]) vld_r[k] <= vin[k];
      end
    end
  end

  assign in_tready = ld[0];
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign load_acc  = in_acc && (in_tuser == FuncLoad);

  // effective dimension minus one, held within 1..MaxDim-1
  always_comb begin
    if (cfg_data < DimW'(2))           cfg_m1 = cell_t'(1);
    else if (cfg_data > DimW'(MaxDim)) cfg_m1 = cell_t'(MaxDim - 1);
    else                               cfg_m1 = cell_t'(cfg_data - DimW'(1));
  end

  // load pointer walks blue fastest, then green, then red
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dimm1_r  <= cell_t'(MaxDim - 1);
      lp_r     <= '0;
      loaded_r <= 1'b0;
    end else if (cfg_valid) begin
      dimm1_r  <= cfg_m1;
      lp_r     <= '0;
      loaded_r <= 1'b0;
    end else if (load_acc) begin
      if (lp_r[2] == dimm1_r) begin
        lp_r[2] <= '0;
        if (lp_r[1] == dimm1_r) begin
          lp_r[1] <= '0;
          if (lp_r[0] == dimm1_r) begin
            lp_r[0]  <= '0;
            loaded_r <= 1'b1;
          end else begin
            lp_r[0] <= lp_r[0] + cell_t'(1);
          end
        end else begin
          lp_r[1] <= lp_r[1] + cell_t'(1);
        end
      end else begin
        lp_r[2] <= lp_r[2] + cell_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_r.pix    <= (in_tuser == FuncPixel);
      s0_r.loaded <= loaded_r;
      s0_r.v      <= in_tdata;
      s0_r.lc     <= lp_r;
    end
  end

  lut3d_front u_front (
    .clk   (clk),
    .ld    (ld[3:1]),
    .s0    (s0_r),
    .dimm1 (dimm1_r),
    .s3    (s3)
  );

  // banks are written and read in the same stage, so request order is kept
  for (genvar k = 0; k < NumBanks; k++) begin : g_bank
    lut3d_ram #(
      .Depth (BankDepth),
      .Width ($bits(ent_t)),
      .Aw    (BankAw)
    ) u_bank (
      .clk   (clk),
      .we    (ld[4] && vld_r[3] && !s3.pix && (s3.cbank[0] == bank_t'(k))),
      .waddr (s3.baddr[k]),
      .wdata (s3.v),
      .re    (ld[4]),
      .raddr (s3.baddr[k]),
      .rdata (q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_r.loaded <= s3.loaded;
      s4_r.v      <= s3.v;
      s4_r.cbank  <= s3.cbank;
      s4_r.w      <= s3.w;
    end
  end

  lut3d_blend u_blend (
    .clk     (clk),
    .ld      (ld[7:5]),
    .s4      (s4_r),
    .q       (q),
    .res     (res),
    .applied (applied)
  );

  assign out_tvalid = vld_r[7];
  assign out_tdata  = res;
  assign out_tuser  = applied;

endmodule
